### src/multi_voice_pcm_mixer_macros.svh
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer_macros
// assertion helpers shared by the mixer rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_PCM_MIXER_MACROS_SVH
`define MULTI_VOICE_PCM_MIXER_MACROS_SVH

// same-cycle implication
`define MVPM_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MVPM_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mvpm_pkg.sv
// ----------------------------------------------------------------------------
// mvpm_pkg
// types and constants of the pcm mixer
// ----------------------------------------------------------------------------
package mvpm_pkg;

    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 18;

    typedef enum logic [3:0] {
        CMD_LOAD      = 4'd0,
        CMD_DEFINE    = 4'd1,
        CMD_PLAY      = 4'd2,
        CMD_MUSIC     = 4'd3,
        CMD_STOP      = 4'd4,
        CMD_MSTOP     = 4'd5,
        CMD_PAUSE     = 4'd6,
        CMD_MPAUSE    = 4'd7,
        CMD_RESUME    = 4'd8,
        CMD_MRESUME   = 4'd9,
        CMD_GAIN      = 4'd10,
        CMD_MGAIN     = 4'd11,
        CMD_MLOOP     = 4'd12,
        CMD_STOPALL   = 4'd13,
        CMD_TICK      = 4'd14
    } cmd_t;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] frames;
        logic        is_stereo;
        logic [17:0] rate;
    } desc_t;

    typedef struct packed {
        logic [32:0] pos;
        logic [19:0] step;
        logic [15:0] gain;
        logic [15:0] base;
        logic [15:0] frames;
        logic [7:0]  id;
        logic [15:0] tag;
    } voice_t;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_P_RD   = 14'b00000000000010,
        ST_P_DESC = 14'b00000000000100,
        ST_P_DIV  = 14'b00000000001000,
        ST_M_RD   = 14'b00000000010000,
        ST_M_CHK  = 14'b00000000100000,
        ST_T_RD   = 14'b00000001000000,
        ST_T_CHK  = 14'b00000010000000,
        ST_T_DIV  = 14'b00000100000000,
        ST_T_SL   = 14'b00001000000000,
        ST_T_SR   = 14'b00010000000000,
        ST_T_MUL  = 14'b00100000000000,
        ST_T_ACC  = 14'b01000000000000,
        ST_T_FIN  = 14'b10000000000000
    } state_t;

endpackage

### src/mvpm_ram.sv
// ----------------------------------------------------------------------------
// mvpm_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mvpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/mvpm_div.sv
// ----------------------------------------------------------------------------
// mvpm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mvpm_div
    import mvpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo,
    output logic [DIV_DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W+1:0] diff;
    logic                 ge;

    // shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        ge    = !diff[DIV_DEN_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

### src/multi_voice_pcm_mixer.sv
// ----------------------------------------------------------------------------
// multi_voice_pcm_mixer
// wavetable sample playback mixer with effect voices and one music voice
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall, one request per command. the block
//   stalls while a command is in progress and takes one request at a time.
//   output channel: out_valid / out_stall, one frame per tick request. the
//   frame sits in an output register, so new requests are taken while it
//   waits; a tick that finishes while the old frame is stalled waits too.
//   config: cfg_valid / cfg_ready writes the output rate; cfg_ready is always
//   high, write it only while the block is idle.
// sequence
//   load word, define sound, music stop/pause/resume, stop all: done in idle.
//   play: sound descriptor read, then the step divider.
//   voice stop/pause/resume/gain: read and check of each effect voice in turn.
//   music gain, music loop: read and check of the music voice.
//   tick: the music voice, then each effect voice; an idle or paused voice is
//   only read, a playing voice is read, mixed and written back, and a voice
//   that wraps its loop first runs the wrap divider. the voice memory read,
//   two sample memory reads per voice and the wrap divider make up its steps.
// reset
//   all voices inactive, sound table not ready, output rate 44100. the sample
//   memory holds nothing defined until loaded.
// ----------------------------------------------------------------------------
`include "multi_voice_pcm_mixer_macros.svh"

module multi_voice_pcm_mixer
    import mvpm_pkg::*;
#(
    parameter int VOICE_COUNT  = 16,
    parameter int SOUND_COUNT  = 256,
    parameter int SAMPLE_WORDS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    // config write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [17:0]        out_rate,
    // command request
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         command,
    input  logic [7:0]         sound_id,
    input  logic [15:0]        instance_req,
    input  logic [15:0]        volume,
    input  logic               loop_flag,
    input  logic [15:0]        sample_address,
    input  logic [15:0]        frame_count,
    input  logic               stereo,
    input  logic [17:0]        sample_rate,
    input  logic signed [15:0] sample_word,
    // frame result
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_left,
    output logic signed [15:0] out_right,
    output logic               music_playing,
    output logic [4:0]         voices_active
);

    localparam int NV  = VOICE_COUNT + 1;
    localparam int VW  = $clog2(NV);
    localparam int SIW = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
    localparam int SAW = $clog2(SAMPLE_WORDS);
    localparam int CW  = $clog2(VOICE_COUNT + 1);
    localparam int AW  = 18 + $clog2(NV);
    localparam int VTW = $bits(voice_t);
    localparam int DTW = $bits(desc_t);

    localparam logic [VW-1:0]        MUSIC_V = VW'(VOICE_COUNT);
    localparam logic [VW-1:0]        LAST_V  = VW'(VOICE_COUNT - 1);
    localparam logic signed [AW-1:0] SAT_HI  = AW'(32767);
    localparam logic signed [AW-1:0] SAT_LO  = -AW'(32768);

    // control state
    state_t            state_reg, state_next;
    logic [VW-1:0]     v_reg;
    logic [NV-1:0]     act_reg;
    logic [NV-1:0]     paused_reg;
    logic [NV-1:0]     loop_reg;
    logic [NV-1:0]     stereo_reg;
    logic [SOUND_COUNT-1:0] ready_reg;
    logic [17:0]       out_rate_reg;
    logic [CW-1:0]     count_reg;
    logic              out_valid_reg;

    // captured command
    cmd_t              cmd_reg;
    logic [7:0]        id_reg;
    logic [15:0]       tag_reg;
    logic [15:0]       gain_reg;
    logic              cmd_loop_reg;

    // mix datapath
    logic [32:0]              pos_reg;
    logic signed [15:0]       sl_reg;
    logic signed [32:0]       prod_l_reg;
    logic signed [32:0]       prod_r_reg;
    logic signed [AW-1:0]     acc_l_reg;
    logic signed [AW-1:0]     acc_r_reg;
    logic signed [15:0]       out_left_reg;
    logic signed [15:0]       out_right_reg;
    logic                     music_reg;
    logic [4:0]               active_reg;

    // input side decode
    logic              in_acc;
    cmd_t              cmd;
    logic [SIW-1:0]    sid_in;
    logic              snd_ok_in;
    logic              ready_in;
    logic [15:0]       gain_in;
    logic [VW-1:0]     pick;
    logic              found;

    // memories
    logic              vram_we, vram_re;
    logic [VTW-1:0]    vram_wdata, vram_rdata;
    voice_t            ve, ve_new;
    logic              snd_we, snd_re;
    logic [DTW-1:0]    snd_rdata;
    desc_t             desc_in, desc;
    logic              sram_we, sram_re;
    logic [SAW-1:0]    sram_raddr;
    logic [15:0]       sram_rdata;

    // divider
    logic                 div_start, div_busy, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den, div_rem;
    logic [19:0]          step_sat;

    // per voice decode
    logic              v_act, v_pause, v_eff, v_last;
    logic [16:0]       f_cur, f_play;
    logic              past_end, can_wrap, skip_voice, match;
    logic [17:0]       off;
    logic [18:0]       sum_l;
    logic [SAW-1:0]    addr_l, addr_r;
    logic signed [32:0] rnd_l, rnd_r;
    logic signed [17:0] term_l, term_r;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cmd       = cmd_t'(command);
    assign sid_in    = SIW'(sound_id);
    assign snd_ok_in = (int'(sound_id) < SOUND_COUNT);
    assign ready_in  = snd_ok_in && ready_reg[sid_in];
    assign gain_in   = (volume > 16'd32768) ? 16'd32768 : volume;

    // first free effect voice, voice 0 when none is free
    always_comb
    begin
        pick  = '0;
        found = 1'b0;
        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            if (!found && !act_reg[i])
            begin
                pick  = VW'(i);
                found = 1'b1;
            end
        end
    end

    assign ve      = voice_t'(vram_rdata);
    assign desc    = desc_t'(snd_rdata);
    assign desc_in = '{base: sample_address, frames: frame_count,
                       is_stereo: stereo, rate: sample_rate};

    assign v_act    = act_reg[v_reg];
    assign v_pause  = paused_reg[v_reg];
    assign v_eff    = (v_reg != MUSIC_V);
    assign v_last   = (v_reg == LAST_V);
    assign f_cur    = ve.pos[32:16];
    assign past_end = (f_cur >= {1'b0, ve.frames});
    assign can_wrap = loop_reg[v_reg] && (ve.frames != 16'd0);
    assign skip_voice = !v_act || v_pause;
    assign match    = v_act && (ve.id == id_reg) && (ve.tag == tag_reg);

    // sample addresses from the (possibly wrapped) position
    assign f_play = pos_reg[32:16];
    assign off    = stereo_reg[v_reg] ? {f_play, 1'b0} : {1'b0, f_play};
    assign sum_l  = 19'(ve.base) + 19'(off);
    assign addr_l = SAW'(sum_l);
    assign addr_r = SAW'(sum_l + 19'(stereo_reg[v_reg]));

    // gain products divided by 32768, truncated toward zero
    assign rnd_l  = prod_l_reg + (prod_l_reg[32] ? 33'sd32767 : 33'sd0);
    assign rnd_r  = prod_r_reg + (prod_r_reg[32] ? 33'sd32767 : 33'sd0);
    assign term_l = rnd_l[32:15];
    assign term_r = rnd_r[32:15];

    // step divider at play, loop wrap divider at tick
    assign div_start = (state_reg == ST_P_DESC) ||
                       ((state_reg == ST_T_CHK) && !skip_voice && past_end && can_wrap);
    assign div_num   = (state_reg == ST_P_DESC) ? {desc.rate, 16'd0} : DIV_NUM_W'(f_cur);
    assign div_den   = (state_reg == ST_P_DESC) ? out_rate_reg : DIV_DEN_W'(ve.frames);
    assign step_sat  = (|div_quo[DIV_NUM_W-1:20]) ? 20'hFFFFF : div_quo[19:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (cmd)
                        CMD_PLAY, CMD_MUSIC:
                            state_next = ready_in ? ST_P_RD : ST_IDLE;
                        CMD_STOP, CMD_PAUSE, CMD_RESUME, CMD_GAIN, CMD_MGAIN, CMD_MLOOP:
                            state_next = ST_M_RD;
                        CMD_TICK:
                            state_next = ST_T_RD;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_P_RD:   state_next = ST_P_DESC;
            ST_P_DESC: state_next = ST_P_DIV;
            ST_P_DIV:  state_next = div_done ? ST_IDLE : ST_P_DIV;
            ST_M_RD:   state_next = ST_M_CHK;
            ST_M_CHK:
            begin
                if (cmd_reg == CMD_MGAIN || cmd_reg == CMD_MLOOP || v_last)
                    state_next = ST_IDLE;
                else
                    state_next = ST_M_RD;
            end
            ST_T_RD:   state_next = ST_T_CHK;
            ST_T_CHK:
            begin
                if (skip_voice || (past_end && !can_wrap))
                    state_next = v_last ? ST_T_FIN : ST_T_RD;
                else if (past_end)
                    state_next = ST_T_DIV;
                else
                    state_next = ST_T_SL;
            end
            ST_T_DIV:  state_next = div_done ? ST_T_SL : ST_T_DIV;
            ST_T_SL:   state_next = ST_T_SR;
            ST_T_SR:   state_next = ST_T_MUL;
            ST_T_MUL:  state_next = ST_T_ACC;
            ST_T_ACC:  state_next = v_last ? ST_T_FIN : ST_T_RD;
            ST_T_FIN:  state_next = (!out_valid_reg || !out_stall) ? ST_IDLE : ST_T_FIN;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v_reg         <= '0;
            act_reg       <= '0;
            paused_reg    <= '0;
            loop_reg      <= '0;
            stereo_reg    <= '0;
            ready_reg     <= '0;
            out_rate_reg  <= 18'd44100;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                out_rate_reg <= out_rate;
            end
            // the final tick state loads the next frame itself
            if (out_valid_reg && !out_stall && state_reg != ST_T_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (cmd)
                            CMD_DEFINE:
                            begin
                                if (snd_ok_in)
                                    ready_reg[sid_in] <= 1'b1;
                            end
                            CMD_PLAY:    v_reg <= pick;
                            CMD_MUSIC:   v_reg <= MUSIC_V;
                            CMD_STOP, CMD_PAUSE, CMD_RESUME, CMD_GAIN:
                                v_reg <= '0;
                            CMD_MSTOP:   act_reg[VOICE_COUNT]    <= 1'b0;
                            CMD_MPAUSE:  paused_reg[VOICE_COUNT] <= 1'b1;
                            CMD_MRESUME: paused_reg[VOICE_COUNT] <= 1'b0;
                            CMD_MGAIN, CMD_MLOOP:
                                v_reg <= MUSIC_V;
                            CMD_STOPALL: act_reg[VOICE_COUNT-1:0] <= '0;
                            CMD_TICK:
                            begin
                                v_reg     <= MUSIC_V;
                                count_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_M_CHK:
                begin
                    unique case (cmd_reg)
                        CMD_STOP:   if (match) act_reg[v_reg]    <= 1'b0;
                        CMD_PAUSE:  if (match) paused_reg[v_reg] <= 1'b1;
                        CMD_RESUME: if (match) paused_reg[v_reg] <= 1'b0;
                        CMD_MLOOP:
                        begin
                            if (act_reg[VOICE_COUNT] && ve.id == id_reg)
                                loop_reg[VOICE_COUNT] <= cmd_loop_reg;
                        end
                        default: ;
                    endcase
                    if (cmd_reg != CMD_MGAIN && cmd_reg != CMD_MLOOP && !v_last)
                        v_reg <= v_reg + VW'(1);
                end
                ST_P_DIV:
                begin
                    if (div_done)
                    begin
                        act_reg[v_reg]    <= 1'b1;
                        loop_reg[v_reg]   <= (cmd_reg == CMD_MUSIC) && cmd_loop_reg;
                        paused_reg[v_reg] <= 1'b0;
                        stereo_reg[v_reg] <= desc.is_stereo;
                    end
                end
                ST_T_CHK:
                begin
                    if (skip_voice)
                    begin
                        if (v_eff && v_act)
                            count_reg <= count_reg + CW'(1);
                        v_reg <= v_eff ? v_reg + VW'(1) : '0;
                    end
                    else if (past_end && !can_wrap)
                    begin
                        // sound ran out: voice ends and adds nothing
                        act_reg[v_reg] <= 1'b0;
                        v_reg <= v_eff ? v_reg + VW'(1) : '0;
                    end
                end
                ST_T_ACC:
                begin
                    if (v_eff)
                        count_reg <= count_reg + CW'(1);
                    v_reg <= v_eff ? v_reg + VW'(1) : '0;
                end
                ST_T_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                        out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_reg      <= cmd;
                    id_reg       <= sound_id;
                    tag_reg      <= instance_req;
                    gain_reg     <= gain_in;
                    cmd_loop_reg <= loop_flag;
                    acc_l_reg    <= '0;
                    acc_r_reg    <= '0;
                end
            end
            ST_T_CHK: pos_reg <= ve.pos;
            ST_T_DIV:
            begin
                if (div_done)
                    pos_reg <= {div_rem[16:0], pos_reg[15:0]};
            end
            ST_T_SR:  sl_reg <= $signed(sram_rdata);
            ST_T_MUL:
            begin
                prod_l_reg <= sl_reg * $signed({1'b0, ve.gain});
                prod_r_reg <= $signed(sram_rdata) * $signed({1'b0, ve.gain});
            end
            ST_T_ACC:
            begin
                acc_l_reg <= acc_l_reg + AW'(term_l);
                acc_r_reg <= acc_r_reg + AW'(term_r);
            end
            ST_T_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    // saturate to 16 bits
                    if (acc_l_reg > SAT_HI)
                        out_left_reg <= 16'sh7FFF;
                    else if (acc_l_reg < SAT_LO)
                        out_left_reg <= 16'sh8000;
                    else
                        out_left_reg <= acc_l_reg[15:0];
                    if (acc_r_reg > SAT_HI)
                        out_right_reg <= 16'sh7FFF;
                    else if (acc_r_reg < SAT_LO)
                        out_right_reg <= 16'sh8000;
                    else
                        out_right_reg <= acc_r_reg[15:0];
                    music_reg  <= act_reg[VOICE_COUNT] && !paused_reg[VOICE_COUNT];
                    active_reg <= 5'(count_reg);
                end
            end
            default: ;
        endcase
    end

    // voice memory: read, modify, write back one voice at a time
    always_comb
    begin
        ve_new  = ve;
        vram_we = 1'b0;
        unique case (state_reg)
            ST_M_CHK:
            begin
                ve_new.gain = gain_reg;
                vram_we = (cmd_reg == CMD_MGAIN) || ((cmd_reg == CMD_GAIN) && match);
            end
            ST_P_DIV:
            begin
                ve_new = '{pos: '0, step: step_sat, gain: gain_reg, base: desc.base,
                           frames: desc.frames, id: id_reg,
                           tag: (cmd_reg == CMD_MUSIC) ? 16'd0 : tag_reg};
                vram_we = div_done;
            end
            ST_T_ACC:
            begin
                ve_new.pos = pos_reg + 33'(ve.step);
                vram_we = 1'b1;
            end
            default: ;
        endcase
    end

    assign vram_wdata = VTW'(ve_new);
    assign vram_re    = (state_reg == ST_M_RD) || (state_reg == ST_T_RD);

    mvpm_ram #(.WIDTH(VTW), .DEPTH(NV)) u_voice_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (v_reg),
        .wdata (vram_wdata),
        .re    (vram_re),
        .raddr (v_reg),
        .rdata (vram_rdata)
    );

    // sound descriptors, ready bits live in flops
    assign snd_we = (state_reg == ST_IDLE) && in_acc && (cmd == CMD_DEFINE) && snd_ok_in;
    assign snd_re = (state_reg == ST_P_RD);

    mvpm_ram #(.WIDTH(DTW), .DEPTH(SOUND_COUNT)) u_sound_ram (
        .clk   (clk),
        .we    (snd_we),
        .waddr (sid_in),
        .wdata (DTW'(desc_in)),
        .re    (snd_re),
        .raddr (SIW'(id_reg)),
        .rdata (snd_rdata)
    );

    // sample memory
    assign sram_we    = (state_reg == ST_IDLE) && in_acc && (cmd == CMD_LOAD);
    assign sram_re    = (state_reg == ST_T_SL) || (state_reg == ST_T_SR);
    assign sram_raddr = (state_reg == ST_T_SL) ? addr_l : addr_r;

    mvpm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (SAW'(sample_address)),
        .wdata (sample_word),
        .re    (sram_re),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    mvpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign out_valid     = out_valid_reg;
    assign out_left      = out_left_reg;
    assign out_right     = out_right_reg;
    assign music_playing = music_reg;
    assign voices_active = active_reg;

    logic fin_now;
    logic play_done;

    assign fin_now   = (state_reg == ST_T_FIN);
    assign play_done = (state_reg == ST_P_DIV) && div_done;

    // a frame only appears at the end of a tick
    `MVPM_ASSERT_NOW(a_frame_from_tick, clk, rst_n, $rose(out_valid_reg), $past(fin_now), "stray frame")
    // the divider is never restarted while it runs
    `MVPM_ASSERT_NOW(a_div_free, clk, rst_n, div_start, !div_busy, "divider started while busy")
    // a finished play leaves its voice active
    `MVPM_ASSERT_NEXT(a_play_active, clk, rst_n, play_done, act_reg[v_reg], "played voice idle")

endmodule
